// ===== rtl/fba_pkg.sv =====
package fba_pkg;

    // Bitmap row geometry and fixed field widths
    localparam int ROW_W      = 32;
    localparam int COL_W      = 5;
    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 16;
    localparam int OUT_IDX_W  = 6;

    localparam logic [SIZE_W-1:0] BLOCK_SIZE_RESET = 16'd16;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EXHAUSTED = 2'd1,
        STATUS_INVALID   = 2'd2
    } status_t;

    typedef enum logic {
        CFG_POOL_BASE  = 1'b0,
        CFG_BLOCK_SIZE = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_A_RD,
        ST_A_CHK,
        ST_MUL,
        ST_F_ADDR,
        ST_DIV,
        ST_F_RD,
        ST_F_CHK,
        ST_DONE
    } state_t;

    // Position of the lowest set bit of a row; zero when the row is empty
    function automatic logic [COL_W-1:0] lowest_set(input logic [ROW_W-1:0] v);
        logic [COL_W-1:0] pos;
        pos = '0;
        for (int i = ROW_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                pos = COL_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

// ===== rtl/fba_if.sv =====
interface fba_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] free_address;

    modport source (output valid, output operation, output free_address, input ready);
    modport sink   (input valid, input operation, input free_address, output ready);
endinterface

interface fba_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] block_address;
    logic [5:0]  block_index;
    logic [1:0]  status;
    logic        exhausted;

    modport source (output valid, output block_address, output block_index,
                    output status, output exhausted, input ready);
    modport sink   (input valid, input block_address, input block_index,
                    input status, input exhausted, output ready);
endinterface

// ===== rtl/fixed_block_bitmap_allocator.sv =====
// Fixed-size block allocator. Allocate returns the lowest free block of a pool of
// NUM_BLOCKS equal blocks as pool_base + index * block_size; free takes any address
// inside an outstanding block and releases it. Free marks live in a synchronous RAM
// of 32-bit rows, all free after reset through per-row valid flags (no clearing
// pass). One request is in work at a time: an allocate reads and checks bitmap
// rows in turn up to the first row with a free block, then forms the address; an
// allocate that finds no free block reports exhausted after the last row. A free
// runs the bit-serial 32-step divider that turns the address offset into a block
// index (skipped when the address lies below the base or the block size is zero).
// A result waits in an output register; a new request is taken once the previous
// result has been loaded there.
module fixed_block_bitmap_allocator #(
    parameter int NUM_BLOCKS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    fba_req_if.sink     req,
    fba_rsp_if.source   rsp
);
    import fba_pkg::*;

    localparam int NUM_ROWS  = (NUM_BLOCKS + ROW_W - 1) / ROW_W;
    localparam int ROW_AW    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int IDX_W     = ROW_AW + COL_W;
    localparam int PROD_W    = IDX_W + SIZE_W;
    localparam int LAST_BITS = NUM_BLOCKS - (NUM_ROWS - 1) * ROW_W;
    localparam logic [ROW_W-1:0] LAST_MASK = ROW_W'({ROW_W{1'b1}} >> (ROW_W - LAST_BITS));
    localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(NUM_ROWS - 1);

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [ROW_AW-1:0]   row_reg, row_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    status_t             status_reg, status_next;
    logic                exhausted_reg, exhausted_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [ADDR_W-1:0]   out_addr_reg, out_addr_next;
    logic [OUT_IDX_W-1:0] out_idx_reg, out_idx_next;
    status_t             out_status_reg, out_status_next;
    logic                out_exh_reg, out_exh_next;
    logic [ADDR_W-1:0]   pool_base_reg;
    logic [SIZE_W-1:0]   block_size_reg;
    logic [NUM_ROWS-1:0] row_valid_reg;
    logic                rd_valid_reg;

    logic                ram_we, ram_re;
    logic [ROW_AW-1:0]   ram_waddr, ram_raddr;
    logic [ROW_W-1:0]    ram_wdata, ram_rdata;
    logic                div_start, div_done;
    logic [ADDR_W-1:0]   div_quotient;
    logic                req_ready, load_rsp;

    logic [ROW_W-1:0]    eff_row, row_mask, free_bits, col_bit;
    logic [COL_W-1:0]    alloc_col;
    logic                row_found, addr_bad, q_out_of_range, blk_free;
    logic [31:0]         idx_ext;

    fba_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_ROWS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fba_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (addr_reg - pool_base_reg),
        .divisor  (block_size_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // A row never written reads as all free
    assign eff_row   = rd_valid_reg ? ram_rdata : '1;
    assign row_mask  = (row_reg == LAST_ROW) ? LAST_MASK : '1;
    assign free_bits = eff_row & row_mask;
    assign row_found = |free_bits;
    assign alloc_col = lowest_set(free_bits);
    assign col_bit   = ROW_W'(1) << idx_reg[COL_W-1:0];
    assign blk_free  = |(eff_row & col_bit);
    assign addr_bad  = (addr_reg < pool_base_reg) || (block_size_reg == '0);
    assign q_out_of_range = div_quotient >= ADDR_W'(NUM_BLOCKS);
    assign idx_ext   = 32'(idx_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = (op_t'(req.operation) == OP_FREE) ? ST_F_ADDR : ST_A_RD;
                end
            end
            ST_A_RD:   state_next = ST_A_CHK;
            ST_A_CHK:
            begin
                if (row_found)
                begin
                    state_next = ST_MUL;
                end
                else if (row_reg == LAST_ROW)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_A_RD;
                end
            end
            ST_MUL:    state_next = ST_DONE;
            ST_F_ADDR: state_next = addr_bad ? ST_DONE : ST_DIV;
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = q_out_of_range ? ST_DONE : ST_F_RD;
                end
            end
            ST_F_RD:   state_next = ST_F_CHK;
            ST_F_CHK:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        req_ready = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = row_reg;
        ram_we    = 1'b0;
        ram_waddr = row_reg;
        ram_wdata = eff_row & ~(ROW_W'(1) << alloc_col);
        div_start = 1'b0;
        load_rsp  = 1'b0;
        case (state_reg)
            ST_IDLE:   req_ready = 1'b1;
            ST_A_RD:   ram_re = 1'b1;
            ST_A_CHK:  ram_we = row_found;
            ST_F_ADDR: div_start = !addr_bad;
            ST_F_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = idx_reg[IDX_W-1:COL_W];
            end
            ST_F_CHK:
            begin
                ram_we    = !blk_free;
                ram_waddr = idx_reg[IDX_W-1:COL_W];
                ram_wdata = eff_row | col_bit;
            end
            ST_DONE:   load_rsp = !rsp_valid_reg || rsp.ready;
            default:   req_ready = 1'b0;
        endcase
    end

    // Datapath next values
    always_comb
    begin
        op_next         = op_reg;
        addr_next       = addr_reg;
        row_next        = row_reg;
        idx_next        = idx_reg;
        prod_next       = prod_reg;
        status_next     = status_reg;
        exhausted_next  = exhausted_reg;
        rsp_valid_next  = rsp_valid_reg;
        out_addr_next   = out_addr_reg;
        out_idx_next    = out_idx_reg;
        out_status_next = out_status_reg;
        out_exh_next    = out_exh_reg;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next     = op_t'(req.operation);
                    addr_next   = req.free_address;
                    row_next    = '0;
                    idx_next    = '0;
                    status_next = STATUS_OK;
                end
            end
            ST_A_CHK:
            begin
                if (row_found)
                begin
                    idx_next = {row_reg, alloc_col};
                end
                else if (row_reg == LAST_ROW)
                begin
                    status_next    = STATUS_EXHAUSTED;
                    exhausted_next = 1'b1;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                end
            end
            ST_MUL:    prod_next = idx_reg * block_size_reg;
            ST_F_ADDR:
            begin
                if (addr_bad)
                begin
                    status_next = STATUS_INVALID;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (q_out_of_range)
                    begin
                        status_next = STATUS_INVALID;
                    end
                    else
                    begin
                        idx_next = div_quotient[IDX_W-1:0];
                    end
                end
            end
            ST_F_CHK:
            begin
                if (blk_free)
                begin
                    status_next = STATUS_INVALID;
                    idx_next    = '0;
                end
                else
                begin
                    exhausted_next = 1'b0;
                end
            end
            ST_DONE:
            begin
                if (load_rsp)
                begin
                    rsp_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_exh_next    = exhausted_reg;
                    out_idx_next    = (status_reg == STATUS_OK) ? idx_ext[OUT_IDX_W-1:0] : '0;
                    out_addr_next   = (status_reg == STATUS_OK && op_reg == OP_ALLOC) ?
                                      pool_base_reg + ADDR_W'(prod_reg) : '0;
                end
            end
            default:   op_next = op_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            exhausted_reg  <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            row_valid_reg  <= '0;
            pool_base_reg  <= '0;
            block_size_reg <= BLOCK_SIZE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            exhausted_reg <= exhausted_next;
            rsp_valid_reg <= rsp_valid_next;
            if (ram_we)
            begin
                row_valid_reg[ram_waddr] <= 1'b1;
            end
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_POOL_BASE:  pool_base_reg  <= cfg_data;
                    CFG_BLOCK_SIZE: block_size_reg <= cfg_data[SIZE_W-1:0];
                    default:        pool_base_reg  <= pool_base_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        addr_reg       <= addr_next;
        row_reg        <= row_next;
        idx_reg        <= idx_next;
        prod_reg       <= prod_next;
        status_reg     <= status_next;
        out_addr_reg   <= out_addr_next;
        out_idx_reg    <= out_idx_next;
        out_status_reg <= out_status_next;
        out_exh_reg    <= out_exh_next;
        if (ram_re)
        begin
            rd_valid_reg <= row_valid_reg[ram_raddr];
        end
    end

    assign req.ready         = req_ready;
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.block_address = out_addr_reg;
    assign rsp.block_index   = out_idx_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.exhausted     = out_exh_reg;

    a_exh_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(exhausted_reg) |-> ($past(state_reg) == ST_A_CHK && $past(op_reg) == OP_ALLOC))
        else $error("exhausted flag set outside a failed allocate");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished while no free was waiting on it");

    a_exh_status: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && out_status_reg == STATUS_EXHAUSTED) |-> out_exh_reg)
        else $error("exhausted result without sticky flag");

    a_free_idx: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_F_RD |-> idx_ext < 32'(NUM_BLOCKS))
        else $error("free index beyond pool reached the bitmap");

endmodule

// ===== rtl/fba_ram.sv =====
module fba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/fba_div.sv =====
module fba_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [fba_pkg::ADDR_W-1:0] dividend,
    input  logic [fba_pkg::SIZE_W-1:0] divisor,
    output logic                      done,
    output logic [fba_pkg::ADDR_W-1:0] quotient
);
    import fba_pkg::*;

    localparam int CNT_W = $clog2(ADDR_W);

    logic              busy_reg,  busy_next;
    logic              done_reg,  done_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic [ADDR_W-1:0] quo_reg,   quo_next;
    logic [SIZE_W-1:0] rem_reg,   rem_next;
    logic [SIZE_W-1:0] dvs_reg,   dvs_next;

    logic [SIZE_W:0]   shifted;
    logic [SIZE_W+1:0] diff;

    // One restoring step per cycle, quotient bits shift in behind the dividend
    assign shifted = {rem_reg, quo_reg[ADDR_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[SIZE_W+1])
            begin
                rem_next = diff[SIZE_W-1:0];
                quo_next = {quo_reg[ADDR_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[SIZE_W-1:0];
                quo_next = {quo_reg[ADDR_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ADDR_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
